[rtl/core/cmap_format4_glyph_lookup_macros.svh]
// Assertion macros for the cmap format 4 lookup checker.
`ifndef CMAP_FORMAT4_GLYPH_LOOKUP_MACROS_SVH
`define CMAP_FORMAT4_GLYPH_LOOKUP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CMAP4_CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CMAP4_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cmap4_pkg.sv]
// Shared constants and types for the cmap format 4 glyph lookup.
package cmap4_pkg;

    localparam int WORD_W          = 16;
    localparam int WADDR_W         = 10;
    localparam int SEG_W           = 15;
    localparam int LONG_W          = 18;
    localparam int TABLE_WORDS_DEF = 1024;

    localparam logic [WORD_W-1:0] FMT_EXPECTED = 16'd4;
    localparam int WORD_FMT      = 0;
    localparam int WORD_SEGX2    = 3;
    localparam int WORD_END_BASE = 7;
    localparam int PAD_WORDS     = 1;

    localparam int CMDQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 2;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic               lookup;
        logic               wr_ok;
        logic [WADDR_W-1:0] addr;
        logic [WORD_W-1:0]  data;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] glyph;
        logic              found;
    } res_t;

endpackage

[rtl/core/cmap_format4_glyph_lookup.sv]
// Top level of the cmap format 4 glyph lookup.
//
// Input channel (push/full): each word is either a table write (func = 0,
// word_address, word_value) or a lookup (func = 1, code_point). Words enter
// a 4-deep command queue and are carried out strictly in order.
// Result channel (empty/pop): one word (glyph_index, found) per lookup, none
// per write, held in a 2-deep result queue; the head shows while empty is low.
// Engine: a write is carried out from the idle state. A lookup's time in
// the engine is set by the table memory, which has one read port: two reads
// per segment (end and start code) plus format, segment count, delta and
// range offset reads, and a glyph-array read when the range offset is
// nonzero. Lookups run one at a time.
// Reset clears both queues and the engine; table contents are not cleared
// and must be written before lookups use them.
// When the result side stalls, the engine holds the next lookup until a
// result slot frees; writes ahead of it still complete, then the input queue
// backs up to full.
module cmap_format4_glyph_lookup #(
    parameter int TABLE_WORDS = cmap4_pkg::TABLE_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           func,
    input  logic [cmap4_pkg::WADDR_W-1:0]  word_address,
    input  logic [cmap4_pkg::WORD_W-1:0]   word_value,
    input  logic [cmap4_pkg::WORD_W-1:0]   code_point,
    output logic                           empty,
    input  logic                           pop,
    output logic [cmap4_pkg::WORD_W-1:0]   glyph_index,
    output logic                           found
);

    logic             cmd_avail;
    cmap4_pkg::cmd_t  cmd;
    logic             cmd_pop;
    logic             res_full;
    logic             res_push;
    cmap4_pkg::res_t  res;
    cmap4_pkg::res_t  head;

    cmap4_front #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .word_address (word_address),
        .word_value   (word_value),
        .code_point   (code_point),
        .cmd_avail    (cmd_avail),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    cmap4_back #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (cmd_avail),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    cmap4_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    assign glyph_index = head.glyph;
    assign found       = head.found;

endmodule

[rtl/core/cmap4_front.sv]
// Input side: takes words, classifies them and queues commands for the engine.
module cmap4_front #(
    parameter int TABLE_WORDS = cmap4_pkg::TABLE_WORDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               func,
    input  logic [cmap4_pkg::WADDR_W-1:0]      word_address,
    input  logic [cmap4_pkg::WORD_W-1:0]       word_value,
    input  logic [cmap4_pkg::WORD_W-1:0]       code_point,
    output logic                               cmd_avail,
    output cmap4_pkg::cmd_t                    cmd,
    input  logic                               cmd_pop
);

    localparam int PW = $clog2(cmap4_pkg::CMDQ_DEPTH);

    cmap4_pkg::cmd_t q_reg [cmap4_pkg::CMDQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     cnt_reg;
    cmap4_pkg::cmd_t entry;
    logic            push_ok;
    logic            pop_ok;

    always_comb
    begin
        entry.lookup = (func == cmap4_pkg::FUNC_LOOKUP);
        entry.wr_ok  = (32'(word_address) < 32'(TABLE_WORDS));
        entry.addr   = word_address;
        entry.data   = entry.lookup ? code_point : word_value;
    end

    assign full      = (cnt_reg == (PW+1)'(cmap4_pkg::CMDQ_DEPTH));
    assign cmd_avail = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_pop && cmd_avail;

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_ok && !pop_ok)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop_ok && !push_ok)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/cmap4_back.sv]
// Engine: holds the subtable memory, performs writes and walks segments for lookups.
module cmap4_back #(
    parameter int TABLE_WORDS = cmap4_pkg::TABLE_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_avail,
    input  cmap4_pkg::cmd_t      cmd,
    output logic                 cmd_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output cmap4_pkg::res_t      res
);

    localparam int AW = $clog2(TABLE_WORDS);
    localparam int LW = cmap4_pkg::LONG_W;
    localparam int DW = cmap4_pkg::WORD_W;
    localparam int SW = cmap4_pkg::SEG_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FMT,
        ST_SEG,
        ST_START,
        ST_CMP,
        ST_TAIL,
        ST_DLT,
        ST_RO,
        ST_GLY
    } state_t;

    state_t          state_reg,        state_next;
    logic [DW-1:0]   code_reg,         code_next;
    logic [SW-1:0]   segs_reg,         segs_next;
    logic [SW-1:0]   idx_reg,          idx_next;
    logic [DW-1:0]   end_reg,          end_next;
    logic            hit_reg,          hit_next;
    logic [SW-1:0]   seg_reg,          seg_next;
    logic [LW-1:0]   start_base_reg,   start_base_next;
    logic [LW-1:0]   delta_base_reg,   delta_base_next;
    logic [LW-1:0]   ro_base_reg,      ro_base_next;
    logic [DW-1:0]   diff_reg,         diff_next;
    logic [LW-1:0]   ro_addr_reg,      ro_addr_next;
    logic [DW-1:0]   delta_reg,        delta_next;
    logic            res_valid_reg,    res_valid_next;
    logic [DW-1:0]   res_glyph_reg,    res_glyph_next;
    logic            res_found_reg,    res_found_next;

    logic [DW-1:0]   mem [TABLE_WORDS];
    logic [DW-1:0]   rdata_reg;
    logic [AW-1:0]   raddr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;

    logic [SW-1:0]   segs_w;
    logic [LW-1:0]   seg_top_w;
    logic [SW-1:0]   idx_inc;
    logic [LW-1:0]   end_addr_w;
    logic [LW-1:0]   start_addr_w;
    logic [LW-1:0]   dlt_addr_w;
    logic [LW-1:0]   ro_addr_w;
    logic [LW-1:0]   gly_addr_w;
    logic            cmp_hit;

    assign mem_waddr = AW'(cmd.addr);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.data;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        segs_w       = rdata_reg[DW-1:1];
        seg_top_w    = LW'(cmap4_pkg::WORD_END_BASE + cmap4_pkg::PAD_WORDS)
                       + (LW'(segs_w) << 2);
        idx_inc      = idx_reg + 1'b1;
        end_addr_w   = LW'(cmap4_pkg::WORD_END_BASE) + LW'(idx_inc);
        start_addr_w = start_base_reg + LW'(idx_reg);
        dlt_addr_w   = delta_base_reg + LW'(seg_reg);
        ro_addr_w    = ro_base_reg + LW'(seg_reg);
        gly_addr_w   = ro_addr_reg + LW'(rdata_reg[DW-1:1]) + LW'(diff_reg);
        cmp_hit      = (end_reg >= code_reg) && (rdata_reg <= code_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        code_next       = code_reg;
        segs_next       = segs_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        hit_next        = hit_reg;
        seg_next        = seg_reg;
        start_base_next = start_base_reg;
        delta_base_next = delta_base_reg;
        ro_base_next    = ro_base_reg;
        diff_next       = diff_reg;
        ro_addr_next    = ro_addr_reg;
        delta_next      = delta_reg;
        res_valid_next  = 1'b0;
        res_glyph_next  = res_glyph_reg;
        res_found_next  = res_found_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        raddr           = AW'(cmap4_pkg::WORD_FMT);

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_avail)
                begin
                    if (!cmd.lookup)
                    begin
                        cmd_pop = 1'b1;
                        mem_we  = cmd.wr_ok;
                    end
                    else if (!res_full && !res_valid_reg)
                    begin
                        cmd_pop    = 1'b1;
                        code_next  = cmd.data;
                        state_next = ST_FMT;
                    end
                end
            end
            ST_FMT:
            begin
                raddr = AW'(cmap4_pkg::WORD_SEGX2);
                if (rdata_reg != cmap4_pkg::FMT_EXPECTED)
                begin
                    res_valid_next = 1'b1;
                    res_glyph_next = '0;
                    res_found_next = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                raddr = AW'(cmap4_pkg::WORD_END_BASE);
                if ((seg_top_w > LW'(TABLE_WORDS)) || (segs_w == '0))
                begin
                    res_valid_next = 1'b1;
                    res_glyph_next = '0;
                    res_found_next = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    segs_next       = segs_w;
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    start_base_next = LW'(cmap4_pkg::WORD_END_BASE + cmap4_pkg::PAD_WORDS)
                                      + LW'(segs_w);
                    delta_base_next = LW'(cmap4_pkg::WORD_END_BASE + cmap4_pkg::PAD_WORDS)
                                      + (LW'(segs_w) << 1);
                    ro_base_next    = LW'(cmap4_pkg::WORD_END_BASE + cmap4_pkg::PAD_WORDS)
                                      + (LW'(segs_w) << 1) + LW'(segs_w);
                    state_next      = ST_START;
                end
            end
            ST_START:
            begin
                end_next   = rdata_reg;
                raddr      = start_addr_w[AW-1:0];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (cmp_hit)
                begin
                    hit_next  = 1'b1;
                    seg_next  = idx_reg;
                    diff_next = code_reg - rdata_reg;
                end
                if (idx_inc == segs_reg)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    idx_next   = idx_inc;
                    raddr      = end_addr_w[AW-1:0];
                    state_next = ST_START;
                end
            end
            ST_TAIL:
            begin
                if (!hit_reg)
                begin
                    res_valid_next = 1'b1;
                    res_glyph_next = '0;
                    res_found_next = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    raddr        = dlt_addr_w[AW-1:0];
                    ro_addr_next = ro_addr_w;
                    state_next   = ST_DLT;
                end
            end
            ST_DLT:
            begin
                delta_next = rdata_reg;
                raddr      = ro_addr_reg[AW-1:0];
                state_next = ST_RO;
            end
            ST_RO:
            begin
                if (rdata_reg == '0)
                begin
                    res_valid_next = 1'b1;
                    res_glyph_next = code_reg + delta_reg;
                    res_found_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (gly_addr_w >= LW'(TABLE_WORDS))
                begin
                    res_valid_next = 1'b1;
                    res_glyph_next = '0;
                    res_found_next = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    raddr      = gly_addr_w[AW-1:0];
                    state_next = ST_GLY;
                end
            end
            ST_GLY:
            begin
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
                if (rdata_reg == '0)
                begin
                    res_glyph_next = '0;
                    res_found_next = 1'b0;
                end
                else
                begin
                    res_glyph_next = rdata_reg + delta_reg;
                    res_found_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            code_reg       <= '0;
            segs_reg       <= '0;
            idx_reg        <= '0;
            end_reg        <= '0;
            hit_reg        <= 1'b0;
            seg_reg        <= '0;
            start_base_reg <= '0;
            delta_base_reg <= '0;
            ro_base_reg    <= '0;
            diff_reg       <= '0;
            ro_addr_reg    <= '0;
            delta_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_glyph_reg  <= '0;
            res_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            code_reg       <= code_next;
            segs_reg       <= segs_next;
            idx_reg        <= idx_next;
            end_reg        <= end_next;
            hit_reg        <= hit_next;
            seg_reg        <= seg_next;
            start_base_reg <= start_base_next;
            delta_base_reg <= delta_base_next;
            ro_base_reg    <= ro_base_next;
            diff_reg       <= diff_next;
            ro_addr_reg    <= ro_addr_next;
            delta_reg      <= delta_next;
            res_valid_reg  <= res_valid_next;
            res_glyph_reg  <= res_glyph_next;
            res_found_reg  <= res_found_next;
        end
    end

    assign res_push  = res_valid_reg;
    assign res.glyph = res_glyph_reg;
    assign res.found = res_found_reg;

endmodule

[rtl/core/cmap4_outq.sv]
// Result queue between the engine and the output port.
module cmap4_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  cmap4_pkg::res_t  res,
    output logic             res_full,
    input  logic             pop,
    output logic             empty,
    output cmap4_pkg::res_t  head
);

    localparam int PW = $clog2(cmap4_pkg::RESQ_DEPTH);

    cmap4_pkg::res_t q_reg [cmap4_pkg::RESQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     cnt_reg;
    logic            push_ok;
    logic            pop_ok;

    assign res_full = (cnt_reg == (PW+1)'(cmap4_pkg::RESQ_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head     = q_reg[rd_ptr_reg];
    assign push_ok  = res_push && !res_full;
    assign pop_ok   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_ok && !pop_ok)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop_ok && !push_ok)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/cmap4_checker.sv]
// Port-level checker for the cmap format 4 glyph lookup, with its bind.
`include "cmap_format4_glyph_lookup_macros.svh"

module cmap4_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          pop,
    input logic                          empty,
    input logic [cmap4_pkg::WORD_W-1:0]  glyph_index,
    input logic                          found
);

    `CMAP4_CHK_SAME(a_miss_zero, !empty && !found, glyph_index == '0, "miss with nonzero glyph")
    `CMAP4_CHK_SAME(a_full_by_push, $rose(full), $past(push && !full), "full rose without a push")
    `CMAP4_CHK_NEXT(a_hold, !empty && !pop, !empty && $stable(glyph_index) && $stable(found), "result changed while stalled")

endmodule

bind cmap_format4_glyph_lookup cmap4_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .pop         (pop),
    .empty       (empty),
    .glyph_index (glyph_index),
    .found       (found)
);
